@@ rtl/mbxp_pkg.sv @@
// shared types and constants of the masked bit extract packer
package mbxp_pkg;

    // word geometry
    localparam int WORD_W = 64;
    localparam int RANK_W = 6;
    localparam int CNT_W  = 7;

    // configuration port
    localparam int CFG_IDX_W     = 3;
    localparam int WC_W          = 3;
    localparam int NUM_MASK_REGS = 4;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MASK_0     = 3'd1;

    // rank of every mask bit: number of set mask bits below it
    typedef logic [WORD_W-1:0][RANK_W-1:0] t_rank_vec;

    // result pushes from the merge stage into the output queue
    typedef struct packed {
        logic first;
        logic first_last;
        logic second;
    } t_push;

endpackage

@@ rtl/mbxp_cfg_regs.sv @@
// configuration registers with precomputed bit ranks and popcounts per mask word
module mbxp_cfg_regs
    import mbxp_pkg::*;
#(
    parameter int MAX_WORDS = 4,
    parameter int WI_W      = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [WORD_W-1:0]     i_cfg_wdata,
    input  logic [WI_W-1:0]       i_acc_idx,
    input  logic [WI_W-1:0]       i_ext_idx,
    output logic [WC_W-1:0]       o_word_count,
    output logic [CNT_W-1:0]      o_pcnt,
    output logic [WORD_W-1:0]     o_mask,
    output t_rank_vec             o_rank
);

    logic [WC_W-1:0]   r_word_count;
    logic [WORD_W-1:0] r_mask [MAX_WORDS];
    t_rank_vec         r_rank [MAX_WORDS];
    logic [CNT_W-1:0]  r_pcnt [MAX_WORDS];

    t_rank_vec         n_rank;
    logic [CNT_W-1:0]  n_pcnt;

    // log-step prefix count over the written mask
    always_comb begin
        logic [WORD_W-1:0][CNT_W-1:0] cnt;
        logic [WORD_W-1:0][CNT_W-1:0] nxt;
        for (int b = 0; b < WORD_W; b++) begin
            cnt[b] = CNT_W'(i_cfg_wdata[b]);
        end
        for (int k = 0; k < RANK_W; k++) begin
            for (int b = 0; b < WORD_W; b++) begin
                if (b >= (1 << k)) begin
                    nxt[b] = cnt[b] + cnt[b - (1 << k)];
                end else begin
                    nxt[b] = cnt[b];
                end
            end
            cnt = nxt;
        end
        for (int b = 0; b < WORD_W; b++) begin
            n_rank[b] = RANK_W'(cnt[b] - CNT_W'(i_cfg_wdata[b]));
        end
        n_pcnt = cnt[WORD_W-1];
    end

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_count <= WC_W'(1);
            for (int i = 0; i < MAX_WORDS; i++) begin
                r_mask[i] <= '0;
                r_rank[i] <= '0;
                r_pcnt[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == REG_WORD_COUNT) begin
                r_word_count <= i_cfg_wdata[WC_W-1:0];
            end
            for (int i = 0; i < MAX_WORDS; i++) begin
                if (i < NUM_MASK_REGS &&
                    i_cfg_index == CFG_IDX_W'(int'(REG_MASK_0) + i)) begin
                    r_mask[i] <= i_cfg_wdata;
                    r_rank[i] <= n_rank;
                    r_pcnt[i] <= n_pcnt;
                end
            end
        end
    end

    // selection for the accept stage and the extract stage
    assign o_word_count = r_word_count;
    assign o_pcnt       = r_pcnt[i_acc_idx];
    assign o_mask       = r_mask[i_ext_idx];
    assign o_rank       = r_rank[i_ext_idx];

endmodule

@@ rtl/mbxp_extract.sv @@
// parallel bit extract of every lane word under one shared mask
module mbxp_extract
    import mbxp_pkg::*;
#(
    parameter int LANES = 4
) (
    input  logic [LANES*WORD_W-1:0] i_lanes,
    input  logic [WORD_W-1:0]       i_mask,
    input  t_rank_vec               i_rank,
    output logic [LANES*WORD_W-1:0] o_packed
);

    // sel[p][b]: source bit b lands on packed position p
    logic [WORD_W-1:0][WORD_W-1:0] sel;

    always_comb begin
        for (int p = 0; p < WORD_W; p++) begin
            for (int b = 0; b < WORD_W; b++) begin
                sel[p][b] = i_mask[b] && (i_rank[b] == RANK_W'(p));
            end
        end
    end

    // gather per lane
    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            for (int p = 0; p < WORD_W; p++) begin
                o_packed[l*WORD_W + p] = |(i_lanes[l*WORD_W +: WORD_W] & sel[p]);
            end
        end
    end

endmodule

@@ rtl/mbxp_out_queue.sv @@
// four-entry result queue, takes up to two results per cycle
module mbxp_out_queue
    import mbxp_pkg::*;
#(
    parameter int DATA_W = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_push             i_push,
    input  logic [DATA_W-1:0] i_data_first,
    input  logic [DATA_W-1:0] i_data_second,
    output logic              o_room,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [DATA_W-1:0] o_data,
    output logic              o_last
);

    localparam int DEPTH = 4;
    localparam int PTR_W = 2;
    localparam int CNT_QW = 3;

    logic [DATA_W-1:0] r_data [DEPTH];
    logic              r_last [DEPTH];
    logic [PTR_W-1:0]  r_wr;
    logic [PTR_W-1:0]  r_rd;
    logic [CNT_QW-1:0] r_count;

    logic              pop;
    logic [PTR_W-1:0]  second_ptr;
    logic [CNT_QW-1:0] push_cnt;

    assign pop        = o_valid && i_ready;
    assign second_ptr = i_push.first ? r_wr + PTR_W'(1) : r_wr;
    assign push_cnt   = CNT_QW'(i_push.first) + CNT_QW'(i_push.second);

    // room for two more results, judged on the registered fill
    assign o_room  = (r_count <= CNT_QW'(DEPTH - 2));
    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rd];
    assign o_last  = r_last[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_data[r_wr] <= i_data_first;
            r_last[r_wr] <= i_push.first_last;
        end
        if (i_push.second) begin
            r_data[second_ptr] <= i_data_second;
            r_last[second_ptr] <= 1'b1;
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + PTR_W'(push_cnt);
            r_rd    <= r_rd + PTR_W'(pop);
            r_count <= r_count + push_cnt - CNT_QW'(pop);
        end
    end

    // checks
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_QW'(DEPTH))
        else $error("result queue overflow");

    a_push_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.first || i_push.second) |-> o_room)
        else $error("result pushed without room");

endmodule

@@ rtl/masked_bit_extract_packer.sv @@
// top level: masked bit extract and pack of four interleaved lane streams
// path: an accepted transfer passes stage a and stage b into the result queue, then m_axis
// throughput: one input transfer per cycle while the queue has room for two more results;
//   the extract and merge stages both run in each cycle that the pipeline advances, and a
//   batch end can add one extra result, absorbed by the four-entry result queue
// reset (i_rst_n, synchronous): clears accumulators, fill, word index, pipeline and queue;
//   word_count returns to 1 and all masks to zero
module masked_bit_extract_packer
    import mbxp_pkg::*;
#(
    parameter int MAX_WORDS = 4,
    parameter int LANES     = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    // configuration write port
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [WORD_W-1:0]       i_cfg_wdata,
    // input stream
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [LANES*WORD_W-1:0] s_axis_tdata,  // lane_0, lane_1, ... from bit 0 up
    input  logic                    s_axis_tlast,  // last_group
    // result stream
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [LANES*WORD_W-1:0] m_axis_tdata,  // slot_0, slot_1, ... from bit 0 up
    output logic                    m_axis_tlast   // last_vector
);

    localparam int WI_W  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int DATA_W = LANES * WORD_W;
    localparam logic [3:0] MAX_WC = 4'(MAX_WORDS);

    // stream state
    logic [RANK_W-1:0] r_fill;
    logic [WI_W-1:0]   r_wi;

    // stage a: captured transfer and decided control
    logic              r_a_valid;
    logic [DATA_W-1:0] r_a_lanes;
    logic [WI_W-1:0]   r_a_wi;
    logic [RANK_W-1:0] r_a_shift;
    logic              r_a_full;
    logic              r_a_final;
    logic              r_a_last_full;
    logic              r_a_flush;

    // stage b: extracted words
    logic              r_b_valid;
    logic [DATA_W-1:0] r_b_y;
    logic [RANK_W-1:0] r_b_shift;
    logic              r_b_full;
    logic              r_b_final;
    logic              r_b_last_full;
    logic              r_b_flush;

    // accumulators
    logic [DATA_W-1:0] r_acc;

    logic              advance;
    logic              accepted;
    logic [WC_W-1:0]   word_count;
    logic [CNT_W-1:0]  pcnt;
    logic [WORD_W-1:0] ext_mask;
    t_rank_vec         ext_rank;
    logic [DATA_W-1:0] ext_y;
    logic [3:0]        wc_eff;
    logic              last_word;
    logic              final_word;
    logic [CNT_W-1:0]  total;
    logic [RANK_W-1:0] n_fill;
    logic [WI_W-1:0]   n_wi;

    logic [DATA_W-1:0] merged;
    logic [DATA_W-1:0] carry;
    logic [DATA_W-1:0] n_acc;
    logic [DATA_W-1:0] flush_data;
    t_push             push;
    logic              q_room;

    // configuration
    mbxp_cfg_regs #(
        .MAX_WORDS (MAX_WORDS),
        .WI_W      (WI_W)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_acc_idx    (r_wi),
        .i_ext_idx    (r_a_wi),
        .o_word_count (word_count),
        .o_pcnt       (pcnt),
        .o_mask       (ext_mask),
        .o_rank       (ext_rank)
    );

    // the whole pipeline moves together while the queue has room
    assign advance       = q_room;
    assign s_axis_tready = advance;
    assign accepted      = s_axis_tvalid && advance;

    // group position and fill for the incoming transfer
    always_comb begin
        if (word_count == '0) begin
            wc_eff = 4'd1;
        end else if (4'(word_count) > MAX_WC) begin
            wc_eff = MAX_WC;
        end else begin
            wc_eff = 4'(word_count);
        end
        last_word  = (4'(r_wi) + 4'd1 >= wc_eff);
        final_word = last_word && s_axis_tlast;
        total      = CNT_W'(r_fill) + pcnt;
        n_fill     = final_word ? '0 : total[RANK_W-1:0];
        n_wi       = last_word ? '0 : r_wi + WI_W'(1);
    end

    // stream state update on each accepted transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_wi   <= '0;
        end else if (accepted) begin
            r_fill <= n_fill;
            r_wi   <= n_wi;
        end
    end

    // stage a register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (advance) begin
            r_a_valid <= accepted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accepted) begin
            r_a_lanes     <= s_axis_tdata;
            r_a_wi        <= r_wi;
            r_a_shift     <= r_fill;
            r_a_full      <= total[CNT_W-1];
            r_a_final     <= final_word;
            r_a_last_full <= final_word && total[CNT_W-1] && (total[RANK_W-1:0] == '0);
            r_a_flush     <= final_word && (total[RANK_W-1:0] != '0);
        end
    end

    // bit gather
    mbxp_extract #(
        .LANES (LANES)
    ) u_extract (
        .i_lanes  (r_a_lanes),
        .i_mask   (ext_mask),
        .i_rank   (ext_rank),
        .o_packed (ext_y)
    );

    // stage b register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (advance) begin
            r_b_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_a_valid) begin
            r_b_y         <= ext_y;
            r_b_shift     <= r_a_shift;
            r_b_full      <= r_a_full;
            r_b_final     <= r_a_final;
            r_b_last_full <= r_a_last_full;
            r_b_flush     <= r_a_flush;
        end
    end

    // merge at the fill position; bits past 64 spill into carry
    always_comb begin
        logic [2*WORD_W-1:0] wide;
        for (int l = 0; l < LANES; l++) begin
            wide = {{WORD_W{1'b0}}, r_b_y[l*WORD_W +: WORD_W]} << r_b_shift;
            merged[l*WORD_W +: WORD_W] = r_acc[l*WORD_W +: WORD_W] | wide[WORD_W-1:0];
            carry[l*WORD_W +: WORD_W]  = wide[2*WORD_W-1:WORD_W];
        end
    end

    // results and next accumulator; a nonzero fill is flushed at batch end
    always_comb begin
        push.first      = 1'b0;
        push.first_last = r_b_last_full;
        push.second     = 1'b0;
        flush_data      = r_b_full ? carry : merged;
        n_acc           = r_acc;
        if (advance && r_b_valid) begin
            push.first = r_b_full;
            if (r_b_final) begin
                push.second = r_b_flush;
                n_acc = '0;
            end else begin
                n_acc = flush_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else begin
            r_acc <= n_acc;
        end
    end

    // output queue
    mbxp_out_queue #(
        .DATA_W (DATA_W)
    ) u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_data_first  (merged),
        .i_data_second (flush_data),
        .o_room        (q_room),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_data        (m_axis_tdata),
        .o_last        (m_axis_tlast)
    );

    // checks
    a_batch_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accepted && final_word) |=> (r_fill == '0 && r_wi == '0))
        else $error("stream state not cleared at batch end");

    a_word_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accepted && !last_word) |=> (r_wi == $past(r_wi) + WI_W'(1)))
        else $error("word index did not advance");

    a_last_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_b_valid && r_b_last_full) |-> (push.first && !push.second))
        else $error("exact final vector followed by a flush");

    a_flush_only_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push.second |-> (r_b_valid && r_b_final))
        else $error("flush outside batch end");

endmodule
